FILE: src/war_pkg.sv
// ----------------------------------------------------------------------------
// war_pkg: shared types and constants
// Field widths, configuration register indexes and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package war_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int WIN_W      = 5;
  localparam int SLOP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOP_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOP_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HIGH = 3'd5;

  typedef struct packed {
    logic load;
    logic read;
    logic update;
    logic div_step;
    logic finish;
  } war_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } war_sts_t;

endpackage

FILE: src/war_ctrl.sv
// ----------------------------------------------------------------------------
// war_ctrl: item sequencer
// Steps one item through load, store read, window update, serial divide
// and result write.
// ----------------------------------------------------------------------------
module war_ctrl import war_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output war_cmd_t cmd,
  input  war_sts_t sts
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/war_dpath.sv
// ----------------------------------------------------------------------------
// war_dpath: sample window datapath
// Configuration registers, sample ring memory, running sum, bit-serial
// divider, deadband test and result register.
// ----------------------------------------------------------------------------
module war_dpath import war_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [SAMPLE_W-1:0]   in_distance,
  input  logic                  in_force_report,
  input  war_cmd_t              cmd,
  output war_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_report_valid,
  output logic [SAMPLE_W-1:0]   out_report_value,
  output logic [SAMPLE_W-1:0]   out_window_average
);

  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = $clog2(SUM_W);

  logic                mode_r;
  logic [WIN_W-1:0]    win_r;
  logic [SLOP_W-1:0]   slop_low_r;
  logic [SLOP_W-1:0]   slop_high_r;
  logic [SAMPLE_W-1:0] bound_low_r;
  logic [SAMPLE_W-1:0] bound_high_r;

  logic [AW-1:0]       pos_r;
  logic [WIN_W-1:0]    fill_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] last_r;

  logic [SAMPLE_W-1:0] dist_r;
  logic                force_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                filling_r;
  logic [WIN_W-1:0]    rem_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                out_valid_r;
  logic                out_rv_r;
  logic [SAMPLE_W-1:0] out_val_r;
  logic [SAMPLE_W-1:0] out_avg_r;

  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];

  logic [WIN_W-1:0]    eff_win;
  logic                filling_now;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum_nxt;
  logic [AW:0]         pos_p1;
  logic [AW-1:0]       pos_nxt;
  logic [WIN_W:0]      trial;
  logic                ge;
  logic [WIN_W-1:0]    rem_nxt;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] tested;
  logic [SAMPLE_W:0]   low_edge;
  logic [SAMPLE_W:0]   high_edge;
  logic                outside;
  logic                in_bounds;
  logic                report;

  always_comb begin
    if (win_r == '0) begin
      eff_win = WIN_W'(1);
    end else if (32'(win_r) > 32'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = win_r;
    end
  end

  assign filling_now = fill_r < eff_win;
  assign old_sample  = filling_now ? '0 : rd_data_r;
  assign sum_nxt     = sum_r - SUM_W'(old_sample) + SUM_W'(dist_r);
  assign pos_p1      = {1'b0, pos_r} + 1'b1;
  assign pos_nxt     = (32'(pos_p1) >= 32'(eff_win)) ? '0 : pos_p1[AW-1:0];

  assign trial   = {rem_r, quo_r[SUM_W-1]};
  assign ge      = trial >= {1'b0, eff_win};
  assign rem_nxt = ge ? WIN_W'(trial - {1'b0, eff_win}) : trial[WIN_W-1:0];

  assign avg       = quo_r[SAMPLE_W-1:0];
  assign tested    = mode_r ? avg : dist_r;
  assign low_edge  = {1'b0, tested} + (SAMPLE_W+1)'(slop_low_r);
  assign high_edge = {1'b0, last_r} + (SAMPLE_W+1)'(slop_high_r);
  assign outside   = (low_edge < {1'b0, last_r}) || ({1'b0, tested} > high_edge);
  assign in_bounds = (tested >= bound_low_r) && (tested <= bound_high_r);
  assign report    = !filling_r && (force_r || (outside && in_bounds));

  assign sts.div_last = cnt_r == CNT_W'(SUM_W - 1);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b1;
      win_r        <= WIN_W'(16);
      slop_low_r   <= SLOP_W'(1);
      slop_high_r  <= SLOP_W'(1);
      bound_low_r  <= '0;
      bound_high_r <= '1;
      pos_r        <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      last_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:       mode_r       <= cfg_wdata[0];
          CFG_WINDOW: begin
            win_r  <= cfg_wdata[WIN_W-1:0];
            pos_r  <= '0;
            fill_r <= '0;
            sum_r  <= '0;
          end
          CFG_SLOP_LOW:   slop_low_r   <= cfg_wdata[SLOP_W-1:0];
          CFG_SLOP_HIGH:  slop_high_r  <= cfg_wdata[SLOP_W-1:0];
          CFG_BOUND_LOW:  bound_low_r  <= cfg_wdata[SAMPLE_W-1:0];
          CFG_BOUND_HIGH: bound_high_r <= cfg_wdata[SAMPLE_W-1:0];
          default: begin
          end
        endcase
      end else if (cmd.update) begin
        sum_r <= sum_nxt;
        pos_r <= pos_nxt;
        if (filling_now) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (report) begin
          last_r <= tested;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dist_r  <= in_distance;
      force_r <= in_force_report;
    end
    if (cmd.read) begin
      rd_data_r <= mem[pos_r];
    end
    if (cmd.update) begin
      mem[pos_r] <= dist_r;
      filling_r  <= filling_now;
      quo_r      <= sum_nxt;
      rem_r      <= '0;
      cnt_r      <= '0;
    end
    if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.finish) begin
      out_rv_r  <= report;
      out_val_r <= report ? tested : '0;
      out_avg_r <= avg;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_report_valid   = out_rv_r;
  assign out_report_value   = out_val_r;
  assign out_window_average = out_avg_r;

endmodule

FILE: src/windowed_average_change_reporter.sv
// ----------------------------------------------------------------------------
// windowed_average_change_reporter: moving average with deadband reporting
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------
//   in      | in_valid / in_ready    | in_distance, in_force_report
//   out     | out_valid / out_ready  | out_report_valid, out_report_value,
//           |                        | out_window_average
//   cfg     | cfg_we                 | cfg_index, cfg_wdata
//
// An item is accepted only once the previous one has finished; the
// bit-serial divider retires one quotient bit per cycle.
// Reset is synchronous; the sample memory is not cleared, the fill count
// masks entries not yet written since reset or a window write.
// The result register holds a finished item while out_ready is low; the
// next item waits in the final step until that register is taken.
// ----------------------------------------------------------------------------
module windowed_average_change_reporter import war_pkg::*; #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_distance,
  input  logic                  in_force_report,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_report_valid,
  output logic [SAMPLE_W-1:0]   out_report_value,
  output logic [SAMPLE_W-1:0]   out_window_average
);

  war_cmd_t cmd;
  war_sts_t sts;

  war_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  war_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_distance        (in_distance),
    .in_force_report    (in_force_report),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_report_valid   (out_report_valid),
    .out_report_value   (out_report_value),
    .out_window_average (out_window_average)
  );

endmodule

FILE: src/war_chk.sv
// ----------------------------------------------------------------------------
// war_chk: port checker
// Watches the top-level ports for result and sequencing rules.
// ----------------------------------------------------------------------------
module war_chk import war_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_report_valid,
  input logic [SAMPLE_W-1:0]   out_report_value,
  input logic [SAMPLE_W-1:0]   out_window_average
);

  a_value_zero_when_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_report_valid |-> out_report_value == '0)
    else $error("report value nonzero without report");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_report_valid)
      && $stable(out_report_value) && $stable(out_window_average))
    else $error("result changed while stalled");

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_no_result_right_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind windowed_average_change_reporter war_chk u_chk (.*);

FILE: tb/sv/tb_windowed_average_change_reporter.sv
// ----------------------------------------------------------------------------
// tb_windowed_average_change_reporter: self-checking bench for the reporter
// Drives distance items through the valid/ready input and predicts, per
// item, the report flag, report value and window average from an in-bench
// model of the sample ring, running sum and deadband. Results are checked
// in order against that prediction while both sides idle at random, with
// a no-idle stretch and one long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module tb_windowed_average_change_reporter;
  import war_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 7;
  localparam int MAX_WIN       = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int STUCK_LIMIT   = 4000;
  localparam int IDLE_PCT      = 24;

  localparam logic MODE_RAW     = 1'b0;
  localparam logic MODE_AVERAGE = 1'b1;

  typedef struct {
    logic                rep_valid;
    logic [SAMPLE_W-1:0] rep_value;
    logic [SAMPLE_W-1:0] avg;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_distance = '0;
  logic                  in_force_report = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_report_valid;
  logic [SAMPLE_W-1:0]   out_report_value;
  logic [SAMPLE_W-1:0]   out_window_average;

  // predicted block state
  logic [SAMPLE_W-1:0] hist_store [MAX_WIN];
  int unsigned         hist_pos;
  int unsigned         hist_fill;
  logic [15:0]         hist_sum;
  logic [SAMPLE_W-1:0] last_report;
  logic                avg_mode;
  logic [WIN_W-1:0]    win_count;
  logic [SLOP_W-1:0]   slop_lo;
  logic [SLOP_W-1:0]   slop_hi;
  logic [SAMPLE_W-1:0] bound_lo;
  logic [SAMPLE_W-1:0] bound_hi;

  report_t pending_reports [$];
  int      fail_count = 0;
  int      stuck_cycles = 0;
  bit      gaps_on = 1'b1;
  bit      hold_req = 1'b0;

  windowed_average_change_reporter #(.MAX_WINDOW(MAX_WIN)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_distance        (in_distance),
    .in_force_report    (in_force_report),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_report_valid   (out_report_valid),
    .out_report_value   (out_report_value),
    .out_window_average (out_window_average)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic void clear_history();
    for (int i = 0; i < MAX_WIN; i++) hist_store[i] = '0;
    hist_pos  = 0;
    hist_fill = 0;
    hist_sum  = '0;
  endfunction

  function automatic void reset_predictor();
    avg_mode    = MODE_AVERAGE;
    win_count   = 5'd16;
    slop_lo     = 8'd1;
    slop_hi     = 8'd1;
    bound_lo    = 12'd0;
    bound_hi    = 12'd4095;
    last_report = '0;
    clear_history();
  endfunction

  function automatic bit leaves_deadband(input logic [SAMPLE_W-1:0] v);
    int x;
    int last;
    bit outside;
    bit allowed;
    x       = int'(v);
    last    = int'(last_report);
    outside = (x < last - int'(slop_lo)) || (x > last + int'(slop_hi));
    allowed = (x >= int'(bound_lo)) && (x <= int'(bound_hi));
    return outside && allowed;
  endfunction

  function automatic void predict_report(input logic [SAMPLE_W-1:0] distance,
                                         input logic frc);
    int unsigned         n;
    int unsigned         pos;
    bit                  fire;
    logic [SAMPLE_W-1:0] avg;
    report_t             r;
    n = (win_count == 0) ? 1 : ((win_count > MAX_WIN) ? MAX_WIN : int'(win_count));
    fire = frc;
    if (avg_mode == MODE_RAW && leaves_deadband(distance)) fire = 1'b1;
    pos = (hist_pos >= n) ? 0 : hist_pos;
    hist_sum = hist_sum - 16'(hist_store[pos]) + 16'(distance);
    hist_store[pos] = distance;
    pos++;
    hist_pos = (pos >= n) ? 0 : pos;
    avg = SAMPLE_W'(hist_sum / 16'(n));
    if (avg_mode == MODE_AVERAGE && leaves_deadband(avg)) fire = 1'b1;
    r.avg = avg;
    r.rep_valid = 1'b0;
    r.rep_value = '0;
    if (hist_fill < n) begin
      hist_fill++;
    end else if (fire) begin
      last_report = (avg_mode == MODE_AVERAGE) ? avg : distance;
      r.rep_valid = 1'b1;
      r.rep_value = last_report;
    end
    pending_reports.push_back(r);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_MODE:       avg_mode = val[0];
      CFG_WINDOW: begin
        win_count = val[WIN_W-1:0];
        clear_history();
      end
      CFG_SLOP_LOW:   slop_lo = val[SLOP_W-1:0];
      CFG_SLOP_HIGH:  slop_hi = val[SLOP_W-1:0];
      CFG_BOUND_LOW:  bound_lo = val[SAMPLE_W-1:0];
      CFG_BOUND_HIGH: bound_hi = val[SAMPLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_distance(input logic [SAMPLE_W-1:0] distance, input logic frc);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_distance     <= distance;
    in_force_report <= frc;
    do @(posedge clk); while (!in_ready);
    predict_report(distance, frc);
  endtask

  task automatic drain_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int unsigned pick_extreme(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return lo;
    if (r < 4) return hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic randomize_config();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    int unsigned w;
    write_reg(CFG_MODE, $urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 9);
      case (r)
        0: w = 0;
        1: w = 1;
        2: w = 16;
        3: w = 31;
        4: w = $urandom_range(17, 30);
        default: w = $urandom_range(1, 8);
      endcase
      write_reg(CFG_WINDOW, w);
    end
    write_reg(CFG_SLOP_LOW, pick_extreme(0, 255));
    write_reg(CFG_SLOP_HIGH, pick_extreme(0, 255));
    lo = pick_extreme(0, 4095);
    hi = pick_extreme(0, 4095);
    if (lo > hi && $urandom_range(0, 9) < 7) begin
      r  = lo;
      lo = hi;
      hi = r;
    end
    write_reg(CFG_BOUND_LOW, lo);
    write_reg(CFG_BOUND_HIGH, hi);
  endtask

  task automatic send_random_distances(input int count);
    int                  r;
    int                  target;
    logic [SAMPLE_W-1:0] distance;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        distance = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      end else if (r < 35) begin
        distance = SAMPLE_W'($urandom_range(0, 4095));
      end else begin
        target = int'(last_report) - int'(slop_lo) - 4
                 + int'($urandom_range(0, int'(slop_lo) + int'(slop_hi) + 8));
        if (target < 0) target = 0;
        if (target > 4095) target = 4095;
        distance = SAMPLE_W'(target);
      end
      send_distance(distance, $urandom_range(0, 99) < 10);
    end
  endtask

  task automatic test_window_saturation();
    write_reg(CFG_WINDOW, 0);
    send_distance(12'd4095, 1'b0);
    send_distance(12'd0, 1'b0);
    send_distance(12'd4095, 1'b0);
    send_distance(12'd4095, 1'b1);
    send_distance(12'd0, 1'b0);
    drain_reports();
  endtask

  task automatic test_raw_deadband();
    write_reg(CFG_MODE, MODE_RAW);
    write_reg(CFG_WINDOW, 1);
    write_reg(CFG_SLOP_LOW, 0);
    write_reg(CFG_SLOP_HIGH, 255);
    send_distance(12'd100, 1'b0);
    send_distance(12'd100, 1'b1);
    send_distance(12'd99, 1'b0);
    send_distance(12'd354, 1'b0);
    send_distance(12'd355, 1'b0);
    send_distance(12'd0, 1'b1);
    drain_reports();
  endtask

  task automatic test_crossed_bounds();
    write_reg(CFG_BOUND_LOW, 4095);
    write_reg(CFG_BOUND_HIGH, 0);
    send_distance(12'd4095, 1'b0);
    send_distance(12'd0, 1'b0);
    send_distance(12'd2000, 1'b0);
    send_distance(12'd2000, 1'b1);
    drain_reports();
  endtask

  task automatic test_window_write_keeps_last();
    write_reg(CFG_MODE, MODE_AVERAGE);
    write_reg(CFG_SLOP_LOW, 1);
    write_reg(CFG_SLOP_HIGH, 1);
    write_reg(CFG_BOUND_LOW, 0);
    write_reg(CFG_BOUND_HIGH, 4095);
    write_reg(CFG_WINDOW, 2);
    repeat (3) send_distance(12'd10, 1'b0);
    drain_reports();
    write_reg(CFG_WINDOW, 2);
    repeat (3) send_distance(12'd12, 1'b0);
    drain_reports();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 11; p++) begin
      randomize_config();
      send_random_distances(45);
      drain_reports();
    end
  endtask

  task automatic test_no_idle_stretch();
    gaps_on = 1'b0;
    randomize_config();
    send_random_distances(60);
    drain_reports();
    gaps_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    write_reg(CFG_WINDOW, 3);
    hold_req = 1'b1;
    send_random_distances(40);
    drain_reports();
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    report_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: report_valid %0d report_value %0d window_average %0d",
               out_report_valid, out_report_value, out_window_average);
        fail_count++;
      end else begin
        exp_r = pending_reports.pop_front();
        if (out_report_valid !== exp_r.rep_valid) begin
          $error("report_valid: expected %0d, got %0d", exp_r.rep_valid, out_report_valid);
          fail_count++;
        end
        if (out_report_value !== exp_r.rep_value) begin
          $error("report_value: expected %0d, got %0d", exp_r.rep_value, out_report_value);
          fail_count++;
        end
        if (out_window_average !== exp_r.avg) begin
          $error("window_average: expected %0d, got %0d", exp_r.avg, out_window_average);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_window_saturation();
    test_raw_deadband();
    test_crossed_bounds();
    test_window_write_keeps_last();
    test_random_phases();
    test_no_idle_stretch();
    test_receiver_hold();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
